[rtl/smt_pkg.sv]
// Shared constants, widths and the arctangent table for the swerve module target.
package smt_pkg;

    localparam int IN_W        = 112;
    localparam int OUT_W       = 40;
    localparam int CNT_W       = 13;
    localparam int SPEED_W     = 24;
    localparam int TURN_W      = 24;
    localparam int CORDIC_STEPS = 17;
    localparam int ROOT_W      = 17;
    localparam int RAD_W       = 34;

    localparam logic [TURN_W-1:0] HALF_TURN     = 24'h80_0000;
    localparam logic [TURN_W-1:0] QUARTER_TURN  = 24'h40_0000;
    localparam logic [TURN_W-1:0] THREE_QUARTER = 24'hC0_0000;
    localparam logic [TURN_W-1:0] ROUND_HALF    = 24'h80_0000;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7F_FFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh80_0000;

    function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] i);
        logic [TURN_W-1:0] a;
        case (i)
            5'd0:    a = 24'd2097152;
            5'd1:    a = 24'd1238021;
            5'd2:    a = 24'd654136;
            5'd3:    a = 24'd332050;
            5'd4:    a = 24'd166669;
            5'd5:    a = 24'd83416;
            5'd6:    a = 24'd41718;
            5'd7:    a = 24'd20860;
            5'd8:    a = 24'd10430;
            5'd9:    a = 24'd5215;
            5'd10:   a = 24'd2608;
            5'd11:   a = 24'd1304;
            5'd12:   a = 24'd652;
            5'd13:   a = 24'd326;
            5'd14:   a = 24'd163;
            5'd15:   a = 24'd81;
            5'd16:   a = 24'd41;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/smt_cnt_mod.sv]
// Reduction of a raw encoder count modulo the encoder span.
module smt_cnt_mod #(
    parameter int SPAN = 8191,
    parameter int SW   = 13
) (
    input  logic [12:0]   raw,
    output logic [SW-1:0] red
);

    localparam int KM   = (SW >= 13) ? 1 : 14 - SW;
    localparam int RW   = 17;

    logic [RW-1:0] r;

    always_comb
    begin
        r = RW'(raw);
        for (int k = KM - 1; k >= 0; k--)
        begin
            if (r >= (RW'(SPAN) << k))
            begin
                r = r - (RW'(SPAN) << k);
            end
        end
        red = r[SW-1:0];
    end

endmodule

[rtl/swerve_module_target.sv]
// Top level: pipelined swerve wheel kinematics, CORDIC heading and square-root speed.
//
// One wheel item can enter every cycle while the output is not stalled. The pipeline
// length is set by the 17-step CORDIC heading pipeline and the 17-step square-root
// pipeline, which run side by side. Around them sit the velocity, heading, flip,
// scaling and count stages. The flip test compares the heading, scaled by the span, with
// the count offset, so no divider is needed. Each stage holds its item until the next
// stage is free. Bubbles are squeezed out, and input is taken while a finished result
// still waits on the output.
module swerve_module_target #(
    parameter int ENCODER_SPAN = 8191,
    parameter int GEAR_FACTOR  = 19
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // cmd_x, cmd_y, cmd_w, arm_x, arm_y, encoder_zero, encoder_now, zero pad
    input  logic [smt_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // target_count, wheel_speed, zero pad
    output logic [smt_pkg::OUT_W-1:0]  m_tdata
);

    localparam int SW      = $clog2(ENCODER_SPAN + 1);
    localparam int GW      = $clog2(GEAR_FACTOR + 1);
    localparam int MW      = smt_pkg::ROOT_W + GW;
    localparam int PW      = smt_pkg::TURN_W + SW;
    localparam int NW      = smt_pkg::TURN_W + SW + 3;
    localparam int NST     = 26;
    localparam int ST_MUL  = 1;
    localparam int ST_VEL  = 2;
    localparam int ST_SQ   = 3;
    localparam int ST_SUM  = 4;
    localparam int C0      = 4;
    localparam int Q0      = 5;
    localparam int ST_HEAD = 22;
    localparam int ST_FLIP = 23;
    localparam int ST_SPD  = 24;
    localparam int ST_OUT  = 25;

    localparam logic signed [NW-1:0] SPAN_N = NW'(ENCODER_SPAN);
    localparam logic signed [NW-1:0] QS     = NW'(smt_pkg::QUARTER_TURN) * SPAN_N;
    localparam logic signed [NW-1:0] QS3    = NW'(smt_pkg::THREE_QUARTER) * SPAN_N;

    typedef struct packed {
        logic signed [15:0]                 cmd_x;
        logic signed [15:0]                 cmd_y;
        logic signed [15:0]                 cmd_w;
        logic signed [15:0]                 arm_x;
        logic signed [15:0]                 arm_y;
        logic [12:0]                        zraw;
        logic [12:0]                        nraw;
        logic [SW-1:0]                      zero;
        logic [SW-1:0]                      now;
        logic signed [31:0]                 px;
        logic signed [31:0]                 py;
        logic signed [16:0]                 vx;
        logic signed [16:0]                 vy;
        logic [smt_pkg::RAD_W-1:0]          sx;
        logic [smt_pkg::RAD_W-1:0]          sy;
        logic [smt_pkg::RAD_W-1:0]          rad;
        logic [smt_pkg::RAD_W-1:0]          root;
        logic signed [31:0]                 cx;
        logic signed [31:0]                 cy;
        logic [smt_pkg::TURN_W-1:0]         cz;
        logic                               zvec;
        logic [SW:0]                        drem;
        logic                               flip;
        logic [smt_pkg::TURN_W-1:0]         head;
        logic [MW-1:0]                      smag;
        logic signed [smt_pkg::SPEED_W-1:0] speed;
        logic [PW-1:0]                      prod;
        logic [smt_pkg::CNT_W-1:0]          tcount;
    } stg_t;

    function automatic stg_t cordic_step(input stg_t a, input int i);
        stg_t               b;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic [smt_pkg::TURN_W-1:0] at;
        b  = a;
        dx = a.cy >>> i;
        dy = a.cx >>> i;
        at = smt_pkg::atan_turn(5'(i));
        if (a.cy > 32'sd0)
        begin
            b.cx = a.cx + dx;
            b.cy = a.cy - dy;
            b.cz = a.cz + at;
        end
        else
        begin
            b.cx = a.cx - dx;
            b.cy = a.cy + dy;
            b.cz = a.cz - at;
        end
        return b;
    endfunction

    function automatic stg_t sqrt_step(input stg_t a, input int k);
        stg_t                      b;
        logic [smt_pkg::RAD_W-1:0] bt;
        logic [smt_pkg::RAD_W-1:0] t;
        b  = a;
        bt = smt_pkg::RAD_W'(1) << (2 * (16 - k));
        t  = a.root + bt;
        if (a.rad >= t)
        begin
            b.rad  = a.rad - t;
            b.root = (a.root >> 1) + bt;
        end
        else
        begin
            b.root = a.root >> 1;
        end
        return b;
    endfunction

    stg_t              pipe_reg [NST];
    stg_t              in_stage;
    logic [NST-1:0]    v_reg;
    logic [NST-1:0]    rdy;
    logic [SW-1:0]     zero_red;
    logic [SW-1:0]     now_red;

    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || m_tready;
        for (int s = NST - 2; s >= 0; s--)
        begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {3'b000, pipe_reg[NST-1].speed, pipe_reg[NST-1].tcount};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (rdy[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        in_stage       = '0;
        in_stage.cmd_x = s_tdata[15:0];
        in_stage.cmd_y = s_tdata[31:16];
        in_stage.cmd_w = s_tdata[47:32];
        in_stage.arm_x = s_tdata[63:48];
        in_stage.arm_y = s_tdata[79:64];
        in_stage.zraw  = s_tdata[92:80];
        in_stage.nraw  = s_tdata[105:93];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            pipe_reg[0] <= in_stage;
        end
    end

    smt_cnt_mod #(.SPAN(ENCODER_SPAN), .SW(SW)) u_mod_zero (
        .raw (pipe_reg[0].zraw),
        .red (zero_red)
    );

    smt_cnt_mod #(.SPAN(ENCODER_SPAN), .SW(SW)) u_mod_now (
        .raw (pipe_reg[0].nraw),
        .red (now_red)
    );

    for (genvar s = 1; s < NST; s++)
    begin : g_stage
        stg_t st_next;

        always_comb
        begin
            logic signed [31:0]         rx;
            logic signed [31:0]         ry;
            logic signed [31:0]         xs;
            logic signed [31:0]         ys;
            logic signed [NW-1:0]       nd;
            logic signed [NW-1:0]       hp;
            logic [PW-1:0]              pr;
            logic [SW:0]                sm;
            st_next = pipe_reg[s-1];
            rx = '0;
            ry = '0;
            xs = '0;
            ys = '0;
            nd = '0;
            hp = '0;
            pr = '0;
            sm = '0;
            if (s == ST_MUL)
            begin
                st_next.px   = st_next.cmd_w * st_next.arm_x;
                st_next.py   = st_next.cmd_w * st_next.arm_y;
                st_next.zero = zero_red;
                st_next.now  = now_red;
            end
            if (s == ST_VEL)
            begin
                rx = st_next.px + 32'sd32768;
                ry = st_next.py + 32'sd32768;
                st_next.vx = 17'(st_next.cmd_x) + 17'(rx >>> 16);
                st_next.vy = 17'(st_next.cmd_y) + 17'(ry >>> 16);
                if (st_next.now >= st_next.zero)
                begin
                    st_next.drem = (SW+1)'(st_next.now) - (SW+1)'(st_next.zero);
                end
                else
                begin
                    st_next.drem = (SW+1)'(st_next.now) + (SW+1)'(ENCODER_SPAN)
                                 - (SW+1)'(st_next.zero);
                end
            end
            if (s == ST_SQ)
            begin
                st_next.sx   = 34'(st_next.vx) * 34'(st_next.vx);
                st_next.sy   = 34'(st_next.vy) * 34'(st_next.vy);
                st_next.zvec = (st_next.vx == 17'sd0) && (st_next.vy == 17'sd0);
                xs = {{3{st_next.vx[16]}}, st_next.vx, 12'b0};
                ys = {{3{st_next.vy[16]}}, st_next.vy, 12'b0};
                if (st_next.vx[16])
                begin
                    st_next.cx = -xs;
                    st_next.cy = -ys;
                    st_next.cz = smt_pkg::HALF_TURN;
                end
                else
                begin
                    st_next.cx = xs;
                    st_next.cy = ys;
                    st_next.cz = '0;
                end
            end
            if (s == ST_SUM)
            begin
                st_next.rad  = st_next.sx + st_next.sy;
                st_next.root = '0;
            end
            if (s >= C0 && s < C0 + smt_pkg::CORDIC_STEPS)
            begin
                st_next = cordic_step(st_next, s - C0);
            end
            if (s >= Q0 && s < Q0 + smt_pkg::ROOT_W)
            begin
                st_next = sqrt_step(st_next, s - Q0);
            end
            if (s == ST_HEAD)
            begin
                st_next.head = st_next.zvec ? '0 : st_next.cz;
                st_next.prod = PW'(st_next.head) * PW'(ENCODER_SPAN);
                st_next.smag = MW'(st_next.root[smt_pkg::ROOT_W-1:0]) * MW'(GEAR_FACTOR);
            end
            if (s == ST_FLIP)
            begin
                nd = NW'(st_next.drem) << smt_pkg::TURN_W;
                hp = NW'(st_next.prod);
                st_next.flip = ((nd < hp - QS) && (nd >= hp - QS3 + SPAN_N))
                            || ((nd >= hp + QS + SPAN_N) && (nd < hp + QS3));
                st_next.head = st_next.flip ? st_next.head + smt_pkg::HALF_TURN
                                            : st_next.head;
            end
            if (s == ST_SPD)
            begin
                if (32'(st_next.smag) >= 32'h0080_0000)
                begin
                    st_next.speed = st_next.flip ? smt_pkg::SPEED_MIN : smt_pkg::SPEED_MAX;
                end
                else if (st_next.flip)
                begin
                    st_next.speed = -24'(st_next.smag);
                end
                else
                begin
                    st_next.speed = 24'(st_next.smag);
                end
                st_next.prod = PW'(st_next.head) * PW'(ENCODER_SPAN);
            end
            if (s == ST_OUT)
            begin
                pr = st_next.prod + PW'(smt_pkg::ROUND_HALF);
                sm = (SW+1)'(pr[PW-1:smt_pkg::TURN_W]) + (SW+1)'(st_next.zero);
                if (sm >= (SW+1)'(ENCODER_SPAN))
                begin
                    sm = sm - (SW+1)'(ENCODER_SPAN);
                end
                st_next.tcount = 13'(sm);
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                pipe_reg[s] <= st_next;
            end
        end
    end

endmodule

[rtl/smt_checker.sv]
// Port-level checker for the swerve module target and its bind.
module smt_checker #(
    parameter int ENCODER_SPAN = 8191
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [smt_pkg::IN_W-1:0]   s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [smt_pkg::OUT_W-1:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while output side is free");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[12:0]) < ENCODER_SPAN || ENCODER_SPAN > 8191))
        else $error("target count outside encoder span");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[39:37] == 3'b000))
        else $error("output pad bits set");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind swerve_module_target smt_checker #(.ENCODER_SPAN(ENCODER_SPAN)) u_smt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_top.sv]
// Self-checking testbench for swerve_module_target: directed, random and backpressure tests.
`timescale 1ns / 100ps

module tb_top;

    localparam int SPAN     = 8191;
    localparam int GEAR     = 19;
    localparam int LIMIT    = 400000;
    localparam int LATENCY  = 25;

    typedef struct packed {
        logic [smt_pkg::CNT_W-1:0]          target_count;
        logic signed [smt_pkg::SPEED_W-1:0] wheel_speed;
    } wheel_cmd_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [smt_pkg::IN_W-1:0]   s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [smt_pkg::OUT_W-1:0]  m_tdata;

    wheel_cmd_t pending_cmds[$];
    int         mismatches;
    int         cycles;
    bit         idle_on;
    int         hold_req;
    int         hold_cnt;
    int         stall_cnt;

    longint atan_tab[17] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                             20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};

    swerve_module_target DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint heading_turns(input longint vx, input longint vy);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = vx * 4096;
        y = vy * 4096;
        z = 0;
        if (vx == 0 && vy == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 64'h80_0000;
        end
        for (int i = 0; i < 17; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
        end
        return z & 64'hFF_FFFF;
    endfunction

    function automatic wheel_cmd_t wheel_command(input logic [smt_pkg::IN_W-1:0] d);
        longint w;
        longint vx;
        longint vy;
        longint zero;
        longint now;
        longint mag;
        longint head;
        longint cur;
        longint diff;
        longint arc;
        longint speed;
        longint cnt;
        wheel_cmd_t r;
        w    = longint'(signed'(d[47:32]));
        vx   = longint'(signed'(d[15:0]))
             + ((w * longint'(signed'(d[63:48])) + 32768) >>> 16);
        vy   = longint'(signed'(d[31:16]))
             + ((w * longint'(signed'(d[79:64])) + 32768) >>> 16);
        zero = longint'(d[92:80]) % SPAN;
        now  = longint'(d[105:93]) % SPAN;
        mag  = root_floor(longint'(vx * vx + vy * vy));
        head = heading_turns(vx, vy);
        cur  = ((now + SPAN - zero) % SPAN) * (64'd1 << 24) / SPAN;
        diff = (head - cur) & 64'hFF_FFFF;
        arc  = (diff <= 64'h80_0000) ? diff : (64'd1 << 24) - diff;
        speed = mag * GEAR;
        if (arc > 64'h40_0000)
        begin
            head  = (head + 64'h80_0000) & 64'hFF_FFFF;
            speed = -speed;
        end
        if (speed > 8388607)
            speed = 8388607;
        if (speed < -8388608)
            speed = -8388608;
        cnt = (head * SPAN + (64'd1 << 23)) >>> 24;
        cnt = (cnt + zero) % SPAN;
        r.target_count = cnt[smt_pkg::CNT_W-1:0];
        r.wheel_speed  = speed[smt_pkg::SPEED_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_cmds.push_back(wheel_command(s_tdata));
    end

    always @(posedge clk)
    begin
        wheel_cmd_t exp_cmd;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %h", m_tdata);
            end
            else
            begin
                exp_cmd = pending_cmds.pop_front();
                if (m_tdata[12:0] !== exp_cmd.target_count
                    || m_tdata[36:13] !== exp_cmd.wheel_speed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: count exp %0d got %0d, speed exp %0d got %0d",
                                 exp_cmd.target_count, m_tdata[12:0],
                                 exp_cmd.wheel_speed, $signed(m_tdata[36:13]));
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  <= 0;
            stall_cnt <= 0;
        end
        else if (hold_req > 0)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_req;
            hold_req  = 0;
        end
        else if (hold_cnt > 0)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (stall_cnt > 0)
        begin
            m_tready  <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready  <= 1'b0;
            stall_cnt <= $urandom_range(0, 6);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL swerve_module_target");
            $finish;
        end
    end

    task automatic send_wheel(input logic signed [15:0] cx, input logic signed [15:0] cy,
                              input logic signed [15:0] cw, input logic signed [15:0] ax,
                              input logic signed [15:0] ay, input logic [12:0] ez,
                              input logic [12:0] en);
        s_tdata  <= {6'd0, en, ez, ay, ax, cw, cy, cx};
        s_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge clk);
        end
    endtask

    task automatic send_random(input int n);
        logic [15:0] f[5];
        int sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 3);
            foreach (f[j])
            begin
                if (sel == 0)
                    f[j] = 16'(signed'($urandom_range(0, 512)) - 256);
                else if (sel == 1 && j >= 2)
                    f[j] = 16'(signed'($urandom_range(0, 8192)) - 4096);
                else
                    f[j] = 16'($urandom);
            end
            send_wheel(f[0], f[1], f[2], f[3], f[4],
                       13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_wheel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 13'd0, 13'd0);
        send_wheel(-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 13'd8191, 13'd0);
        send_wheel(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 13'd0,
                   13'd8191);
        send_wheel(16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 13'd8190, 13'd8191);
        send_wheel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd0);
        send_wheel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd100, 13'd4195);
        send_wheel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd2047);
        send_wheel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd2048);
        send_wheel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd6143);
        send_wheel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd6144);
        send_wheel(16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd2047);
        send_wheel(16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd2048);
        send_wheel(16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd0);
        send_wheel(-16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd0, 13'd0);
        send_wheel(16'sd0, -16'sd256, 16'sd0, 16'sd0, 16'sd0, 13'd8191, 13'd8191);
        send_wheel(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 13'd5000, 13'd1000);
        send_wheel(16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0, 13'd3000, 13'd3000);
        send_wheel(16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd4096, 13'd8191, 13'd1);
        send_wheel(-16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, 13'd1, 13'd8190);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 300;
        send_random(120);
        drain();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        idle_on    = 1'b1;
        hold_req   = 0;
        mismatches = 0;
        cycles     = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_random(1100);
        drain();
        test_backpressure();
        idle_on = 1'b0;
        send_random(380);
        drain();
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("PASS swerve_module_target");
        else
            $display("FAIL swerve_module_target");
        $finish;
    end

endmodule
